>>> sv/wpp_pkg.sv
// Shared constants, codes and control structures of the WAV PCM header parser.
package wpp_pkg;

    localparam int HEADER_BYTES = 44;
    localparam int IDX_W        = 6;
    localparam int DIV_W        = 33;
    localparam int DIV_CNT_W    = 6;
    localparam int PERIOD_W     = 20;
    localparam int OUT_DATA_W   = 136;
    localparam int OUT_USER_W   = 4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [IDX_W-1:0] IDX_FIRST   = 6'd4;
    localparam logic [IDX_W-1:0] IDX_WAVE    = 6'd11;
    localparam logic [IDX_W-1:0] IDX_FMT     = 6'd15;
    localparam logic [IDX_W-1:0] IDX_FORMAT  = 6'd20;
    localparam logic [IDX_W-1:0] IDX_CHAN    = 6'd22;
    localparam logic [IDX_W-1:0] IDX_RATE    = 6'd24;
    localparam logic [IDX_W-1:0] IDX_ALIGN   = 6'd32;
    localparam logic [IDX_W-1:0] IDX_BITS    = 6'd34;
    localparam logic [IDX_W-1:0] IDX_DATA    = 6'd39;
    localparam logic [IDX_W-1:0] IDX_SIZE    = 6'd40;
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(HEADER_BYTES - 1);

    localparam logic [DIV_W-1:0] PERIOD_NUM = 33'd2000000;

    localparam logic [2:0] STAT_SCAN = 3'd0;
    localparam logic [2:0] STAT_HDR  = 3'd1;
    localparam logic [2:0] STAT_PCM  = 3'd2;
    localparam logic [2:0] STAT_PAST = 3'd3;
    localparam logic [2:0] STAT_REJ  = 3'd4;

    localparam logic [1:0] PH_SCAN = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    typedef struct packed {
        logic step;
        logic load_step;
        logic div_start;
        logic div_blocks;
        logic cap_period;
        logic cap_total;
        logic load_hdr;
    } wpp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } wpp_sts_t;

endpackage

>>> sv/wpp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module wpp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [wpp_pkg::DIV_W-1:0] dividend,
    input  logic [wpp_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [wpp_pkg::DIV_W-1:0] quotient
);
    import wpp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W:0]       rem_sh;
    logic [DIV_W+1:0]     diff;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W+1])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/wpp_dp.sv
// Datapath: header capture, block counting, divider and output word register.
module wpp_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wpp_pkg::wpp_cmd_t              cmd,
    output wpp_pkg::wpp_sts_t              sts,
    input  logic [7:0]                     data_byte,
    input  logic                           restart,
    output logic [wpp_pkg::OUT_DATA_W-1:0] out_data,
    output logic [wpp_pkg::OUT_USER_W-1:0] out_user,
    output logic                           out_last
);
    import wpp_pkg::*;

    logic [31:0]         win_reg, win_next, e_win;
    logic [1:0]          phase_reg, phase_next, e_phase;
    logic [IDX_W-1:0]    idx_reg, idx_next, e_idx;
    logic                tags_reg, tags_next, e_tags;
    logic [15:0]         fmt_reg, fmt_next, e_fmt;
    logic [15:0]         chan_reg, chan_next, e_chan;
    logic [31:0]         rate_reg, rate_next, e_rate;
    logic [15:0]         align_reg, align_next, e_align;
    logic [15:0]         bits_reg, bits_next, e_bits;
    logic [31:0]         size_reg, size_next, e_size;
    logic [PERIOD_W-1:0] period_reg, e_period;
    logic [31:0]         total_reg, e_total;
    logic [15:0]         bib_reg, bib_next, e_bib, bib_inc;
    logic [31:0]         bc_reg, bc_next, e_bc, bc_inc;
    logic [2:0]          stat_next;
    logic                bend_next, dend_next, hdr_ok;

    logic [2:0]          o_stat_reg, o_stat_next;
    logic                o_hv_reg, o_hv_next;
    logic [15:0]         o_chan_reg, o_chan_next;
    logic [15:0]         o_bits_reg, o_bits_next;
    logic [15:0]         o_align_reg, o_align_next;
    logic [PERIOD_W-1:0] o_period_reg, o_period_next;
    logic [31:0]         o_total_reg, o_total_next;
    logic [31:0]         o_done_reg, o_done_next;
    logic                o_bend_reg, o_bend_next;
    logic                o_dend_reg, o_dend_next;

    logic                div_done;
    logic [DIV_W-1:0]    div_a, div_b, div_q;

    assign e_win    = restart ? '0 : win_reg;
    assign e_phase  = restart ? PH_SCAN : phase_reg;
    assign e_idx    = restart ? '0 : idx_reg;
    assign e_tags   = restart ? 1'b1 : tags_reg;
    assign e_fmt    = restart ? '0 : fmt_reg;
    assign e_chan   = restart ? '0 : chan_reg;
    assign e_rate   = restart ? '0 : rate_reg;
    assign e_align  = restart ? '0 : align_reg;
    assign e_bits   = restart ? '0 : bits_reg;
    assign e_size   = restart ? '0 : size_reg;
    assign e_period = restart ? '0 : period_reg;
    assign e_total  = restart ? '0 : total_reg;
    assign e_bib    = restart ? '0 : bib_reg;
    assign e_bc     = restart ? '0 : bc_reg;
    assign bib_inc  = e_bib + 16'd1;
    assign bc_inc   = e_bc + 32'd1;

    always_comb
    begin
        win_next   = e_win;
        phase_next = e_phase;
        idx_next   = e_idx;
        tags_next  = e_tags;
        fmt_next   = e_fmt;
        chan_next  = e_chan;
        rate_next  = e_rate;
        align_next = e_align;
        bits_next  = e_bits;
        size_next  = e_size;
        bib_next   = e_bib;
        bc_next    = e_bc;
        stat_next  = STAT_SCAN;
        bend_next  = 1'b0;
        dend_next  = 1'b0;
        hdr_ok     = 1'b0;
        unique case (e_phase)
            PH_SCAN:
            begin
                win_next = {e_win[23:0], data_byte};
                if (win_next == TAG_RIFF)
                begin
                    phase_next = PH_HEAD;
                    idx_next   = IDX_FIRST;
                    tags_next  = 1'b1;
                    stat_next  = STAT_HDR;
                end
            end
            PH_HEAD:
            begin
                win_next  = {e_win[23:0], data_byte};
                stat_next = STAT_HDR;
                if (e_idx == IDX_WAVE && win_next != TAG_WAVE)
                    tags_next = 1'b0;
                if (e_idx == IDX_FMT && win_next != TAG_FMT)
                    tags_next = 1'b0;
                if (e_idx == IDX_DATA && win_next != TAG_DATA)
                    tags_next = 1'b0;
                if (e_idx[IDX_W-1:1] == IDX_FORMAT[IDX_W-1:1])
                    fmt_next[{e_idx[0], 3'b000} +: 8] = data_byte;
                if (e_idx[IDX_W-1:1] == IDX_CHAN[IDX_W-1:1])
                    chan_next[{e_idx[0], 3'b000} +: 8] = data_byte;
                if (e_idx[IDX_W-1:2] == IDX_RATE[IDX_W-1:2])
                    rate_next[{e_idx[1:0], 3'b000} +: 8] = data_byte;
                if (e_idx[IDX_W-1:1] == IDX_ALIGN[IDX_W-1:1])
                    align_next[{e_idx[0], 3'b000} +: 8] = data_byte;
                if (e_idx[IDX_W-1:1] == IDX_BITS[IDX_W-1:1])
                    bits_next[{e_idx[0], 3'b000} +: 8] = data_byte;
                if (e_idx[IDX_W-1:2] == IDX_SIZE[IDX_W-1:2])
                    size_next[{e_idx[1:0], 3'b000} +: 8] = data_byte;
                if (e_idx >= IDX_LAST)
                begin
                    if (e_tags && e_fmt == 16'd1 && e_rate != '0 && e_align != '0)
                    begin
                        hdr_ok     = 1'b1;
                        phase_next = PH_DATA;
                        bib_next   = '0;
                        bc_next    = '0;
                    end
                    else
                    begin
                        stat_next  = STAT_REJ;
                        phase_next = PH_SCAN;
                        win_next   = '0;
                        idx_next   = '0;
                        tags_next  = 1'b1;
                    end
                end
                else
                    idx_next = e_idx + IDX_W'(1);
            end
            PH_DATA:
            begin
                stat_next = STAT_PCM;
                bib_next  = bib_inc;
                if (bib_inc >= e_align)
                begin
                    bib_next  = '0;
                    bend_next = 1'b1;
                    bc_next   = bc_inc;
                    if (bc_inc >= e_total)
                    begin
                        bc_next    = e_total;
                        dend_next  = 1'b1;
                        phase_next = PH_END;
                    end
                end
            end
            PH_END:
            begin
                stat_next = STAT_PAST;
            end
            default:
            begin
                stat_next = STAT_SCAN;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_hdr)
        begin
            o_stat_next   = STAT_HDR;
            o_hv_next     = 1'b1;
            o_chan_next   = chan_reg;
            o_bits_next   = bits_reg;
            o_align_next  = align_reg;
            o_period_next = period_reg;
            o_total_next  = total_reg;
            o_done_next   = bc_reg;
            o_bend_next   = 1'b0;
            o_dend_next   = 1'b0;
        end
        else
        begin
            o_stat_next   = stat_next;
            o_hv_next     = (phase_next == PH_DATA || phase_next == PH_END);
            o_chan_next   = o_hv_next ? chan_next : '0;
            o_bits_next   = o_hv_next ? bits_next : '0;
            o_align_next  = o_hv_next ? align_next : '0;
            o_period_next = o_hv_next ? e_period : '0;
            o_total_next  = o_hv_next ? e_total : '0;
            o_done_next   = bc_next;
            o_bend_next   = bend_next;
            o_dend_next   = dend_next;
        end
    end

    assign div_a = cmd.div_blocks ? {1'b0, size_reg} : PERIOD_NUM + {1'b0, rate_reg};
    assign div_b = cmd.div_blocks ? {{(DIV_W-16){1'b0}}, align_reg} : {rate_reg, 1'b0};

    wpp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            phase_reg  <= PH_SCAN;
            idx_reg    <= '0;
            tags_reg   <= 1'b1;
            fmt_reg    <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            align_reg  <= '0;
            bits_reg   <= '0;
            size_reg   <= '0;
            period_reg <= '0;
            total_reg  <= '0;
            bib_reg    <= '0;
            bc_reg     <= '0;
        end
        else if (cmd.step)
        begin
            win_reg    <= win_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            tags_reg   <= tags_next;
            fmt_reg    <= fmt_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            align_reg  <= align_next;
            bits_reg   <= bits_next;
            size_reg   <= size_next;
            period_reg <= e_period;
            total_reg  <= e_total;
            bib_reg    <= bib_next;
            bc_reg     <= bc_next;
        end
        else if (cmd.cap_period)
            period_reg <= div_q[PERIOD_W-1:0];
        else if (cmd.cap_total)
        begin
            total_reg <= div_q[31:0];
            phase_reg <= (div_q[31:0] == '0) ? PH_END : PH_DATA;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_step || cmd.load_hdr)
        begin
            o_stat_reg   <= o_stat_next;
            o_hv_reg     <= o_hv_next;
            o_chan_reg   <= o_chan_next;
            o_bits_reg   <= o_bits_next;
            o_align_reg  <= o_align_next;
            o_period_reg <= o_period_next;
            o_total_reg  <= o_total_next;
            o_done_reg   <= o_done_next;
            o_bend_reg   <= o_bend_next;
            o_dend_reg   <= o_dend_next;
        end
    end

    assign sts.need_div = hdr_ok;
    assign sts.div_done = div_done;

    assign out_data = {3'b000, o_bend_reg, o_done_reg, o_total_reg, o_period_reg,
                       o_align_reg, o_bits_reg, o_chan_reg};
    assign out_user = {o_hv_reg, o_stat_reg};
    assign out_last = o_dend_reg;

endmodule

>>> sv/wpp_ctrl.sv
// Controller: stream handshake, output valid and division sequencing.
module wpp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  wpp_pkg::wpp_sts_t sts,
    output wpp_pkg::wpp_cmd_t cmd
);
    import wpp_pkg::*;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DIVP = 2'd1;
    localparam logic [1:0] ST_DIVB = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       out_free, acc;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_RUN) && out_free;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.step       = acc;
        cmd.div_blocks = (state_reg == ST_DIVP);
        unique case (state_reg)
            ST_RUN:
            begin
                if (acc && sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVP;
                end
                else
                    cmd.load_step = acc;
            end
            ST_DIVP:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_period = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = ST_DIVB;
                end
            end
            ST_DIVB:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_total = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        mv_next = (cmd.load_step || cmd.load_hdr) ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;

endmodule

>>> sv/wav_pcm_header_parser_unit.sv
// Top level of the WAV PCM header parser: controller, datapath and checks.
// Input stream: one file byte per word on s_tdata; s_tuser high restarts the
// parse (all state cleared) before that byte is taken.
// Output stream: one word per input byte. m_tuser carries the status code and
// the header-valid flag, m_tdata the accepted header values, the block count
// and the block-end flag, m_tlast marks the byte that completes the last block.
// The output word is registered and valid in the cycle after its byte is taken;
// one byte per cycle while not stalled. The last byte of an accepted header
// starts two divisions on a shared one-bit-per-cycle divider (33 steps each):
// that byte's output word appears after both; s_tready stays low meanwhile.
// Reset clears all parser state and empties the output register.
// A stalled receiver holds the output word; the parser keeps s_tready high
// only while its output register is empty or being taken.
module wav_pcm_header_parser_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // data_byte
    input  logic                           s_tuser,  // restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // channels, sample_bits, block_bytes, sample_period_us, total_blocks,
    // blocks_done, block_end, zero fill
    output logic [wpp_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [wpp_pkg::OUT_USER_W-1:0] m_tuser,  // status, header_valid
    output logic                           m_tlast   // data_end
);
    import wpp_pkg::*;

    wpp_cmd_t cmd;
    wpp_sts_t sts;

    wpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .data_byte (s_tdata),
        .restart   (s_tuser),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[132])
        else $error("data end without block end");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[3] |-> m_tdata[99:0] == '0)
        else $error("header fields set without valid header");

    a_done_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3] |-> m_tdata[131:100] <= m_tdata[99:68])
        else $error("block count beyond total");

    a_reject_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:0] == STAT_REJ |-> !m_tuser[3])
        else $error("rejected header flagged valid");
`endif

endmodule
